@@ rtl/ps2_mouse_packet_tracker_defines.svh @@
// Assertion helpers used by the checker file ps2mpt_checker.sv.
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PMT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ps2mpt_pkg.sv @@
`default_nettype none

package ps2mpt_pkg;

    localparam int COORD_W    = 12;
    localparam int BTN_W      = 2;
    localparam int FLAG_W     = 2;
    localparam int DIV_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int BYTE_W     = 8;
    localparam int JOBQ_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic FUNC_PORT = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam int STAT_READY_BIT = 0;
    localparam int STAT_AUX_BIT   = 5;

    localparam logic [BYTE_W-1:0] SYNC_MASK = 8'h08;
    localparam logic [BYTE_W-1:0] OVF_MASK  = 8'hC0;

    localparam logic [DIV_W-1:0] SCALE_RESET = 3'd1;
    localparam logic [DIV_W-1:0] DIV_MIN     = 3'd1;
    localparam logic [DIV_W-1:0] DIV_MAX     = 3'd4;

    localparam int DEF_WIDTH  = 1280;
    localparam int DEF_HEIGHT = 720;
    localparam int HOME_COL   = 640;
    localparam int HOME_ROW   = 360;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] port_status;
        logic [BYTE_W-1:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic               queue_empty;
        logic [COORD_W-1:0] event_x;
        logic [COORD_W-1:0] event_y;
        logic [BTN_W-1:0]   event_buttons;
        logic [FLAG_W-1:0]  event_flags;
    } evt_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BTN_W-1:0]   buttons;
        logic [FLAG_W-1:0]  flags;
    } ring_entry_t;

    typedef struct packed {
        logic              is_pop;
        logic [BTN_W-1:0]  buttons;
        logic [BYTE_W-1:0] dx;
        logic [BYTE_W-1:0] dy;
    } job_t;

    typedef struct packed {
        logic [DIV_W-1:0]      scale;
        logic [CFG_DATA_W-1:0] width;
        logic [CFG_DATA_W-1:0] height;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/ps2mpt_front.sv @@
`default_nettype none

module ps2mpt_front #(
    parameter int STARTUP_DISCARD = 10
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    input  ps2mpt_pkg::cmd_t    cmd,
    output logic                cmd_ready,
    input  wire                 full,
    output logic                push,
    output ps2mpt_pkg::job_t    push_job
);

    localparam int DW = $clog2(STARTUP_DISCARD + 2);

    localparam logic [1:0] PH_HEAD = 2'd0;
    localparam logic [1:0] PH_DX   = 2'd1;
    localparam logic [1:0] PH_DY   = 2'd2;

    logic [1:0]                        phase_reg, phase_next;
    logic [ps2mpt_pkg::BTN_W-1:0]      btn_reg, btn_next;
    logic [ps2mpt_pkg::BYTE_W-1:0]     dx_reg, dx_next;
    logic [DW-1:0]                     discard_reg, discard_next;
    logic                              take;
    logic                              byte_ok;

    assign cmd_ready = !full;
    assign take      = cmd_valid && !full;
    assign byte_ok   = cmd.port_status[ps2mpt_pkg::STAT_READY_BIT]
                    && cmd.port_status[ps2mpt_pkg::STAT_AUX_BIT];

    always_comb
    begin
        phase_next   = phase_reg;
        btn_next     = btn_reg;
        dx_next      = dx_reg;
        discard_next = discard_reg;
        push         = 1'b0;
        push_job.is_pop  = (cmd.func == ps2mpt_pkg::FUNC_POP);
        push_job.buttons = btn_reg;
        push_job.dx      = dx_reg;
        push_job.dy      = cmd.data_byte;
        if (take)
        begin
            if (cmd.func == ps2mpt_pkg::FUNC_POP)
            begin
                push = 1'b1;
            end
            else if (byte_ok)
            begin
                case (phase_reg)
                    PH_DX:
                    begin
                        dx_next    = cmd.data_byte;
                        phase_next = PH_DY;
                    end
                    PH_DY:
                    begin
                        phase_next = PH_HEAD;
                        if (discard_reg != '0)
                        begin
                            discard_next = discard_reg - DW'(1);
                        end
                        else
                        begin
                            push = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HEAD;
                        if (((cmd.data_byte & ps2mpt_pkg::SYNC_MASK) != '0)
                            && ((cmd.data_byte & ps2mpt_pkg::OVF_MASK) == '0))
                        begin
                            btn_next   = cmd.data_byte[ps2mpt_pkg::BTN_W-1:0];
                            phase_next = PH_DX;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEAD;
            btn_reg     <= '0;
            dx_reg      <= '0;
            discard_reg <= DW'(STARTUP_DISCARD);
        end
        else
        begin
            phase_reg   <= phase_next;
            btn_reg     <= btn_next;
            dx_reg      <= dx_next;
            discard_reg <= discard_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ps2mpt_jobq.sv @@
`default_nettype none

module ps2mpt_jobq (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  ps2mpt_pkg::job_t    push_job,
    output logic                full,
    input  wire                 pop,
    output ps2mpt_pkg::job_t    pop_job,
    output logic                not_empty
);

    localparam int DEPTH = ps2mpt_pkg::JOBQ_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    ps2mpt_pkg::job_t  slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ps2mpt_back.sv @@
`default_nettype none

module ps2mpt_back #(
    parameter int QUEUE_DEPTH = 256,
    parameter int COORD_BITS  = 12
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  ps2mpt_pkg::cfg_t    cfg,
    input  wire                 job_valid,
    input  ps2mpt_pkg::job_t    job,
    output logic                job_ready,
    output logic                evt_valid,
    input  wire                 evt_ready,
    output ps2mpt_pkg::evt_t    evt
);

    localparam int QAW   = $clog2(QUEUE_DEPTH);
    localparam int CB    = COORD_BITS;
    localparam int TW    = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;
    localparam int SW    = TW + 1;
    localparam int ACC_W = 9;
    localparam int XW    = ps2mpt_pkg::COORD_W;

    localparam logic [TW-1:0] CAP      = TW'(2 ** COORD_BITS);
    localparam logic [TW-1:0] FALL_W   = TW'(ps2mpt_pkg::DEF_WIDTH);
    localparam logic [TW-1:0] FALL_H   = TW'(ps2mpt_pkg::DEF_HEIGHT);
    localparam logic [15:0]   RECIP3   = 16'd171;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_MOVE = 2'd3;

    typedef struct packed {
        logic signed [ACC_W-1:0] q;
        logic signed [2:0]       r;
    } divres_t;

    function automatic logic [TW-1:0] screen_top(
        input logic [ps2mpt_pkg::CFG_DATA_W-1:0] limit,
        input logic [TW-1:0]                     fallback
    );
        logic [TW-1:0] top;
        top = (limit == '0) ? fallback : TW'(limit);
        if (top > CAP)
        begin
            top = CAP;
        end
        return top;
    endfunction

    function automatic logic [CB-1:0] clamp(
        input logic signed [SW-1:0] v,
        input logic [TW-1:0]        top
    );
        logic [CB-1:0] res;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v >= $signed({1'b0, top}))
        begin
            res = CB'(top - TW'(1));
        end
        else
        begin
            res = CB'(v);
        end
        return res;
    endfunction

    function automatic divres_t div_trunc(
        input logic signed [ACC_W-1:0]       acc,
        input logic [ps2mpt_pkg::DIV_W-1:0]  d
    );
        logic        neg;
        logic [7:0]  mag;
        logic [15:0] prod;
        logic [7:0]  q;
        logic [7:0]  r;
        divres_t     res;
        neg  = acc[ACC_W-1];
        mag  = neg ? 8'(-acc) : acc[7:0];
        prod = 16'(mag) * RECIP3;
        case (d)
            3'd2:
            begin
                q = mag >> 1;
                r = mag & 8'd1;
            end
            3'd3:
            begin
                q = {1'b0, prod[15:9]};
                r = mag - 8'(q * 8'd3);
            end
            3'd4:
            begin
                q = mag >> 2;
                r = mag & 8'd3;
            end
            default:
            begin
                q = mag;
                r = '0;
            end
        endcase
        res.q = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        res.r = neg ? -$signed({1'b0, r[1:0]}) : $signed({1'b0, r[1:0]});
        return res;
    endfunction

    logic [1:0]                      state_reg, state_next;
    logic [QAW-1:0]                  head_reg, head_next;
    logic [QAW-1:0]                  tail_reg, tail_next;
    logic [CB-1:0]                   col_reg, col_next;
    logic [CB-1:0]                   row_reg, row_next;
    logic signed [2:0]               remx_reg, remx_next;
    logic signed [2:0]               remy_reg, remy_next;
    logic [ps2mpt_pkg::BTN_W-1:0]    held_reg, held_next;
    logic [ps2mpt_pkg::BTN_W-1:0]    btn_reg, btn_next;
    logic signed [ACC_W-1:0]         accx_reg, accx_next;
    logic signed [ACC_W-1:0]         accy_reg, accy_next;
    logic signed [ACC_W-1:0]         mx_reg, mx_next;
    logic signed [ACC_W-1:0]         my_reg, my_next;
    logic                            out_valid_reg, out_valid_next;
    ps2mpt_pkg::evt_t                out_reg, out_next;
    ps2mpt_pkg::ring_entry_t         rd_reg;
    ps2mpt_pkg::ring_entry_t         ring [QUEUE_DEPTH];

    logic [ps2mpt_pkg::DIV_W-1:0]    div;
    divres_t                         resx, resy;
    logic signed [SW-1:0]            sumx, sumy;
    logic [CB-1:0]                   new_col, new_row;
    logic                            moved;
    logic                            is_event;
    logic [QAW-1:0]                  head_inc, tail_inc;
    logic                            ring_full;
    logic                            ring_empty;
    logic                            ring_we;
    ps2mpt_pkg::ring_entry_t         wdata;
    logic                            load_out;

    assign job_ready = (state_reg == S_IDLE);
    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;

    assign div = (cfg.scale == '0) ? ps2mpt_pkg::DIV_MIN :
                 (cfg.scale > ps2mpt_pkg::DIV_MAX) ? ps2mpt_pkg::DIV_MAX : cfg.scale;

    assign resx = div_trunc(accx_reg, div);
    assign resy = div_trunc(accy_reg, div);

    assign sumx = $signed({{(SW - CB){1'b0}}, col_reg}) + SW'(mx_reg);
    assign sumy = $signed({{(SW - CB){1'b0}}, row_reg}) - SW'(my_reg);
    assign new_col = clamp(sumx, screen_top(cfg.width, FALL_W));
    assign new_row = clamp(sumy, screen_top(cfg.height, FALL_H));

    assign moved    = (mx_reg != '0) || (my_reg != '0);
    assign is_event = moved || (btn_reg != held_reg);

    assign head_inc   = (head_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QAW'(1);
    assign tail_inc   = (tail_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + QAW'(1);
    assign ring_full  = (head_inc == tail_reg);
    assign ring_empty = (head_reg == tail_reg);
    assign ring_we    = (state_reg == S_MOVE) && is_event && !ring_full;

    assign wdata.x       = XW'(new_col);
    assign wdata.y       = XW'(new_row);
    assign wdata.buttons = btn_reg;
    assign wdata.flags   = {|btn_reg, moved};

    assign load_out = (state_reg == S_POP) && (!out_valid_reg || evt_ready);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        remx_next  = remx_reg;
        remy_next  = remy_reg;
        held_next  = held_reg;
        btn_next   = btn_reg;
        accx_next  = accx_reg;
        accy_next  = accy_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        out_next   = out_reg;
        out_valid_next = out_valid_reg && !evt_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.is_pop)
                    begin
                        state_next = S_POP;
                    end
                    else
                    begin
                        accx_next  = $signed({{(ACC_W - 3){remx_reg[2]}}, remx_reg})
                                   + $signed({job.dx[7], job.dx});
                        accy_next  = $signed({{(ACC_W - 3){remy_reg[2]}}, remy_reg})
                                   + $signed({job.dy[7], job.dy});
                        btn_next   = job.buttons;
                        state_next = S_DIV;
                    end
                end
            end
            S_POP:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    if (ring_empty)
                    begin
                        out_next = '0;
                        out_next.queue_empty = 1'b1;
                    end
                    else
                    begin
                        out_next.queue_empty   = 1'b0;
                        out_next.event_x       = rd_reg.x;
                        out_next.event_y       = rd_reg.y;
                        out_next.event_buttons = rd_reg.buttons;
                        out_next.event_flags   = rd_reg.flags;
                        tail_next = tail_inc;
                    end
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                mx_next    = resx.q;
                my_next    = resy.q;
                remx_next  = resx.r;
                remy_next  = resy.r;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                col_next = new_col;
                row_next = new_row;
                if (is_event)
                begin
                    held_next = btn_reg;
                    if (!ring_full)
                    begin
                        head_next = head_inc;
                    end
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring[head_reg] <= wdata;
        end
        rd_reg <= ring[tail_reg];
    end

    always_ff @(posedge clk)
    begin
        accx_reg <= accx_next;
        accy_reg <= accy_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        btn_reg  <= btn_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            col_reg       <= CB'(ps2mpt_pkg::HOME_COL);
            row_reg       <= CB'(ps2mpt_pkg::HOME_ROW);
            remx_reg      <= '0;
            remy_reg      <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            remx_reg      <= remx_next;
            remy_reg      <= remy_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ps2_mouse_packet_tracker.sv @@
`default_nettype none

// PS/2 mouse packet tracker. Every item is taken by the front end, which
// frames three-byte packets and hands finished packets and pops to the back end
// through a two-entry job queue; cmd_ready drops only while that queue is full.
// A finished packet keeps the back end busy through S_DIV (divide) and S_MOVE (cursor update
// and clamp, event write into the ring), a pop through S_POP, where it waits until the
// previous event has been taken on evt_ready. The ring holds QUEUE_DEPTH - 1 events; events
// found with the ring full are dropped while cursor and buttons still update.
// Configuration writes through cfg_we take effect on the next cycle.
module ps2_mouse_packet_tracker #(
    parameter int QUEUE_DEPTH     = 256,
    parameter int STARTUP_DISCARD = 10,
    parameter int COORD_BITS      = 12
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         cfg_we,
    input  wire  [ps2mpt_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  wire  [ps2mpt_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  wire                                         cmd_valid,
    output logic                                        cmd_ready,
    input  ps2mpt_pkg::cmd_t                            cmd,
    output logic                                        evt_valid,
    input  wire                                         evt_ready,
    output ps2mpt_pkg::evt_t                            evt
);

    ps2mpt_pkg::cfg_t  cfg_reg, cfg_next;
    ps2mpt_pkg::job_t  push_job;
    ps2mpt_pkg::job_t  job;
    logic              push;
    logic              full;
    logic              job_valid;
    logic              job_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ps2mpt_pkg::CFG_SCALE:  cfg_next.scale  = cfg_data[ps2mpt_pkg::DIV_W-1:0];
                ps2mpt_pkg::CFG_WIDTH:  cfg_next.width  = cfg_data;
                ps2mpt_pkg::CFG_HEIGHT: cfg_next.height = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale  <= ps2mpt_pkg::SCALE_RESET;
            cfg_reg.width  <= '0;
            cfg_reg.height <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ps2mpt_front #(
        .STARTUP_DISCARD (STARTUP_DISCARD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .full      (full),
        .push      (push),
        .push_job  (push_job)
    );

    ps2mpt_jobq u_jobq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .pop       (job_valid && job_ready),
        .pop_job   (job),
        .not_empty (job_valid)
    );

    ps2mpt_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt)
    );

endmodule

`default_nettype wire

@@ rtl/ps2mpt_checker.sv @@
`include "ps2_mouse_packet_tracker_defines.svh"
`default_nettype none

module ps2mpt_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               evt_valid,
    input wire               evt_ready,
    input ps2mpt_pkg::evt_t  evt
);

    `PMT_ASSERT_NEXT(a_evt_hold, evt_valid && !evt_ready, evt_valid && $stable(evt), "item dropped or changed while stalled")
    `PMT_ASSERT_NOW(a_empty_zero, evt_valid && evt.queue_empty, (evt.event_x == '0) && (evt.event_y == '0) && (evt.event_buttons == '0) && (evt.event_flags == '0), "empty pop carries nonzero fields")
    `PMT_ASSERT_NOW(a_flag_btn, evt_valid && !evt.queue_empty, evt.event_flags[1] == (evt.event_buttons != '0), "button flag disagrees with buttons")

endmodule

bind ps2_mouse_packet_tracker ps2mpt_checker u_checker (.*);

`default_nettype wire

@@ dv/ps2_mouse_packet_tracker_checker.sv @@
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker_checker #(
    parameter int QUEUE_DEPTH     = 256,
    parameter int STARTUP_DISCARD = 10
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire  [ps2mpt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [ps2mpt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                                  cmd_valid,
    input  wire                                  cmd_ready,
    input  ps2mpt_pkg::cmd_t                     cmd,
    input  wire                                  evt_valid,
    input  wire                                  evt_ready,
    input  ps2mpt_pkg::evt_t                     evt,
    output int                                   fail_count,
    output int                                   pending_results,
    output int                                   results_checked,
    output int                                   events_dropped
);

    import ps2mpt_pkg::*;

    typedef enum logic [1:0] {
        AWAIT_HEADER,
        AWAIT_DX,
        AWAIT_DY
    } frame_state_t;

    logic [DIV_W-1:0]      scale;
    logic [CFG_DATA_W-1:0] width_lim;
    logic [CFG_DATA_W-1:0] height_lim;

    frame_state_t          frame;
    logic [BYTE_W-1:0]     header;
    logic [BYTE_W-1:0]     dx_byte;
    int                    discards;
    int                    col;
    int                    row;
    int                    rem_x;
    int                    rem_y;
    logic                  left_held;
    logic                  right_held;

    ring_entry_t           ring_q[$];
    evt_t                  expected_q[$];

    function automatic int clamp_coord(int v, logic [CFG_DATA_W-1:0] lim, int fallback);
        int top;
        top = (lim != '0) ? int'(lim) : fallback;
        if (top > (1 << COORD_W))
            top = 1 << COORD_W;
        if (v < 0)
            v = 0;
        if (v >= top)
            v = top - 1;
        return v;
    endfunction

    task automatic apply_motion(input logic [BYTE_W-1:0] dy_byte);
        int          div;
        int          acc_x;
        int          acc_y;
        int          mx;
        int          my;
        logic        left;
        logic        right;
        ring_entry_t entry;
        if (scale < DIV_MIN)
            div = int'(DIV_MIN);
        else if (scale > DIV_MAX)
            div = int'(DIV_MAX);
        else
            div = int'(scale);
        acc_x = rem_x + int'($signed(dx_byte));
        acc_y = rem_y + int'($signed(dy_byte));
        mx = acc_x / div;
        my = acc_y / div;
        rem_x = acc_x % div;
        rem_y = acc_y % div;
        col = clamp_coord(col + mx, width_lim, DEF_WIDTH);
        row = clamp_coord(row - my, height_lim, DEF_HEIGHT);
        left = header[0];
        right = header[1];
        if (left == left_held && right == right_held && mx == 0 && my == 0)
            return;
        left_held = left;
        right_held = right;
        if (ring_q.size() >= QUEUE_DEPTH - 1) begin
            events_dropped++;
            return;
        end
        entry.x = col[COORD_W-1:0];
        entry.y = row[COORD_W-1:0];
        entry.buttons = {right, left};
        entry.flags = {left | right, (mx != 0 || my != 0)};
        ring_q.push_back(entry);
    endtask

    task automatic track_item(input cmd_t item);
        evt_t        answer;
        ring_entry_t oldest;
        if (item.func == FUNC_POP) begin
            answer = '0;
            if (ring_q.size() == 0) begin
                answer.queue_empty = 1'b1;
            end
            else begin
                oldest = ring_q.pop_front();
                answer.event_x = oldest.x;
                answer.event_y = oldest.y;
                answer.event_buttons = oldest.buttons;
                answer.event_flags = oldest.flags;
            end
            expected_q.push_back(answer);
        end
        else if (item.port_status[STAT_READY_BIT] && item.port_status[STAT_AUX_BIT]) begin
            case (frame)
                AWAIT_DX:
                begin
                    dx_byte = item.data_byte;
                    frame = AWAIT_DY;
                end
                AWAIT_DY:
                begin
                    frame = AWAIT_HEADER;
                    if (discards != 0)
                        discards--;
                    else
                        apply_motion(item.data_byte);
                end
                default:
                begin
                    frame = AWAIT_HEADER;
                    if ((item.data_byte & SYNC_MASK) != '0 && (item.data_byte & OVF_MASK) == '0)
                    begin
                        header = item.data_byte;
                        frame = AWAIT_DX;
                    end
                end
            endcase
        end
    endtask

    task automatic check_event(input evt_t got);
        evt_t want;
        if (expected_q.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected event: empty=%0d x=%0d y=%0d buttons=%0d flags=%0d",
                     $time, got.queue_empty, got.event_x, got.event_y,
                     got.event_buttons, got.event_flags);
            return;
        end
        want = expected_q.pop_front();
        results_checked++;
        if (got !== want) begin
            fail_count++;
            $display("%0t: event mismatch: expected empty=%0d x=%0d y=%0d buttons=%0d flags=%0d",
                     $time, want.queue_empty, want.event_x, want.event_y,
                     want.event_buttons, want.event_flags);
            $display("%0t:                  actual empty=%0d x=%0d y=%0d buttons=%0d flags=%0d",
                     $time, got.queue_empty, got.event_x, got.event_y,
                     got.event_buttons, got.event_flags);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            scale = SCALE_RESET;
            width_lim = '0;
            height_lim = '0;
            frame = AWAIT_HEADER;
            header = '0;
            dx_byte = '0;
            discards = STARTUP_DISCARD;
            col = HOME_COL;
            row = HOME_ROW;
            rem_x = 0;
            rem_y = 0;
            left_held = 1'b0;
            right_held = 1'b0;
            ring_q.delete();
            expected_q.delete();
            fail_count = 0;
            pending_results = 0;
            results_checked = 0;
            events_dropped = 0;
        end
        else begin
            if (evt_valid && evt_ready)
                check_event(evt);
            if (cmd_valid && cmd_ready)
                track_item(cmd);
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SCALE:  scale = cfg_data[DIV_W-1:0];
                    CFG_WIDTH:  width_lim = cfg_data;
                    CFG_HEIGHT: height_lim = cfg_data;
                    default:    ;
                endcase
            end
            pending_results = expected_q.size();
        end
    end

endmodule

@@ dv/ps2_mouse_packet_tracker_tb.sv @@
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker_tb;

    import ps2mpt_pkg::*;

    localparam int QUEUE_DEPTH     = 256;
    localparam int STARTUP_DISCARD = 10;
    localparam int SETTLE_CYCLES   = 20;

    localparam logic [BYTE_W-1:0] READY_ONLY = 8'd1 << STAT_READY_BIT;
    localparam logic [BYTE_W-1:0] AUX_ONLY   = 8'd1 << STAT_AUX_BIT;
    localparam logic [BYTE_W-1:0] STATUS_OK  = READY_ONLY | AUX_ONLY;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  cmd_valid;
    logic                  cmd_ready;
    cmd_t                  cmd;
    logic                  evt_valid;
    logic                  evt_ready;
    evt_t                  evt;

    int fail_count;
    int pending_results;
    int results_checked;
    int events_dropped;

    int items_sent = 0;
    int settings_used = 0;
    bit sender_burst = 1'b0;
    bit receiver_burst = 1'b0;

    ps2_mouse_packet_tracker #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .STARTUP_DISCARD (STARTUP_DISCARD),
        .COORD_BITS      (COORD_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt)
    );

    ps2_mouse_packet_tracker_checker #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .STARTUP_DISCARD (STARTUP_DISCARD)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd),
        .evt_valid       (evt_valid),
        .evt_ready       (evt_ready),
        .evt             (evt),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .events_dropped  (events_dropped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic cmd_t make_item(logic func, logic [BYTE_W-1:0] status,
                                       logic [BYTE_W-1:0] data);
        cmd_t item;
        item.func = func;
        item.port_status = status;
        item.data_byte = data;
        return item;
    endfunction

    function automatic logic [BYTE_W-1:0] sync_header();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom);
        return (b & ~OVF_MASK) | SYNC_MASK;
    endfunction

    function automatic logic [BYTE_W-1:0] broken_header();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom);
        if ($urandom_range(0, 1) == 0)
            b = b & ~SYNC_MASK;
        else
            b[7:6] = 2'($urandom_range(1, 3));
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] motion_byte();
        int v;
        v = int'($urandom_range(0, 8)) - 4;
        if ($urandom_range(0, 1) == 0)
            v = int'($urandom_range(0, 255));
        return v[7:0];
    endfunction

    function automatic logic [BYTE_W-1:0] nonzero_motion();
        int v;
        v = int'($urandom_range(1, 127));
        if ($urandom_range(0, 1) == 0)
            v = -v;
        return v[7:0];
    endfunction

    task automatic send(input cmd_t item);
        int gap;
        if ($urandom_range(0, 15) == 0)
            sender_burst = !sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd <= item;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (!cmd_ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] data);
        send(make_item(FUNC_PORT, 8'($urandom) | STATUS_OK, data));
    endtask

    task automatic send_ignored();
        logic [BYTE_W-1:0] status;
        status = 8'($urandom);
        case ($urandom_range(0, 2))
            0:       status[STAT_READY_BIT] = 1'b0;
            1:       status[STAT_AUX_BIT] = 1'b0;
            default: status = status & ~STATUS_OK;
        endcase
        send(make_item(FUNC_PORT, status, 8'($urandom)));
    endtask

    task automatic send_pop();
        send(make_item(FUNC_POP, 8'($urandom), 8'($urandom)));
    endtask

    task automatic send_packet(input logic [BYTE_W-1:0] hdr, dx, dy);
        send_byte(hdr);
        if ($urandom_range(0, 9) == 0)
            send_ignored();
        send_byte(dx);
        if ($urandom_range(0, 9) == 0)
            send_ignored();
        send_byte(dy);
    endtask

    // drop valid, drain the event stream, let in-flight packets finish
    task automatic settle();
        cmd_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_screen(input logic [DIV_W-1:0] div,
                                  input logic [CFG_DATA_W-1:0] w, h);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_SCALE;
        cfg_data <= {{(CFG_DATA_W - DIV_W){1'b0}}, div};
        @(negedge clk);
        cfg_index <= CFG_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_mixed(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_packet(sync_header(), motion_byte(), motion_byte());
            else if (pick < 75)
                send_pop();
            else if (pick < 85)
                send_ignored();
            else if (pick < 93)
                send_byte(broken_header());
            else
                send_byte(8'($urandom));
        end
    endtask

    initial
    begin
        int stall;
        evt_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                receiver_burst = !receiver_burst;
            stall = receiver_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                evt_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            evt_ready <= 1'b1;
            do @(posedge clk); while (!(evt_valid && evt_ready));
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SCALE;
        cfg_data = '0;
        cmd_valid = 1'b0;
        cmd = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        settings_used++;

        send_pop();
        send(make_item(FUNC_PORT, 8'h00, 8'h08));
        send(make_item(FUNC_PORT, READY_ONLY, 8'h08));
        send(make_item(FUNC_PORT, AUX_ONLY, 8'h08));
        send_byte(8'h00);
        send_byte(8'h48);
        send_byte(8'h88);
        send(make_item(FUNC_POP, 8'hFF, 8'hFF));
        repeat (STARTUP_DISCARD) send_packet(8'h0B, 8'h7F, 8'h80);
        send_packet(8'h08, 8'h7F, 8'h80);
        send_packet(8'h09, 8'h80, 8'h7F);
        send_packet(8'h0A, 8'h00, 8'h00);
        send_packet(8'h0A, 8'h00, 8'h00);
        repeat (4) send_pop();

        program_screen(3'd4, 12'd1, 12'd1);
        run_mixed(20);
        program_screen(3'd0, 12'd4095, 12'd4095);
        run_mixed(20);
        program_screen(3'd7, 12'd0, 12'd0);
        run_mixed(20);
        program_screen(3'd2, 12'($urandom), 12'($urandom));
        run_mixed(20);
        program_screen(3'd3, 12'($urandom_range(2, 200)), 12'($urandom_range(2, 200)));
        run_mixed(20);
        program_screen(3'd5, 12'd0, 12'd4095);
        run_mixed(20);
        program_screen(3'd6, 12'd4095, 12'd1);
        run_mixed(20);

        // fill the ring past capacity, then drain it
        program_screen(3'd1, 12'd0, 12'd0);
        repeat (QUEUE_DEPTH + 6) send_packet(sync_header(), nonzero_motion(), motion_byte());
        repeat (QUEUE_DEPTH + 6) send_pop();

        program_screen(3'($urandom_range(1, 4)), 12'($urandom), 12'($urandom));
        run_mixed(20);

        settle();
        $display("Drove %0d items through %0d scale and screen settings", items_sent,
                 settings_used);
        $display("Compared %0d events, %0d events fell on a full ring", results_checked,
                 events_dropped);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ ps2_mouse_packet_tracker.f @@
+incdir+rtl
rtl/ps2mpt_pkg.sv
rtl/ps2mpt_front.sv
rtl/ps2mpt_jobq.sv
rtl/ps2mpt_back.sv
rtl/ps2_mouse_packet_tracker.sv
rtl/ps2mpt_checker.sv
dv/ps2_mouse_packet_tracker_checker.sv
dv/ps2_mouse_packet_tracker_tb.sv
